// ===== hdl/i2cbm_pkg.sv =====
// Shared types and constants of the I2C byte master.
package i2cbm_pkg;

  localparam int          TickW           = 16;
  localparam logic [TickW-1:0] PHASE_TICKS_RST = 16'd50;

  localparam logic [4:0]  PHASE_IDLE  = 5'd31;
  localparam logic [4:0]  PH_WR_REL   = 5'd24;
  localparam logic [4:0]  PH_WR_ACK   = 5'd25;
  localparam logic [4:0]  PH_RD_ACK   = 5'd16;
  localparam logic [4:0]  PH_RD_HIGH  = 5'd17;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       cmd_valid;
    cmd_t       mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_level;
  } res_t;

  // Index of the last bus phase of each command.
  function automatic logic [4:0] phase_last(input cmd_t m);
    logic [4:0] r;
    unique case (m)
      CMD_START: r = 5'd3;
      CMD_STOP:  r = 5'd2;
      CMD_WRITE: r = 5'd26;
      CMD_READ:  r = 5'd18;
      default:   r = 5'd3;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/i2cbm_front.sv =====
// Input queue: takes ticks from the bus side and decodes them into items.
module i2cbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                cmd_valid,
  input  logic [1:0]          mode,
  input  logic [7:0]          tx_byte,
  input  logic                send_ack,
  input  logic                sda_in,
  input  logic                deq,
  output logic                avail,
  output i2cbm_pkg::item_t    item
);
  import i2cbm_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;
  item_t      dec;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign wr_en = push && !full;
  assign rd_en = deq && avail;
  assign item  = mem_r[rd_ptr_r];

  always_comb begin
    dec.cmd_valid = cmd_valid;
    dec.mode      = cmd_t'(mode);
    dec.tx_byte   = tx_byte;
    dec.send_ack  = send_ack;
    dec.sda_in    = sda_in;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 2'd1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== hdl/i2cbm_engine.sv =====
// Bus engine: phase counter, pin registers and shift register, one tick per item.
module i2cbm_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  i2cbm_pkg::item_t        item,
  input  logic                    cfg_we,
  input  logic [i2cbm_pkg::TickW-1:0] cfg_data,
  output i2cbm_pkg::res_t         res
);
  import i2cbm_pkg::*;

  logic [TickW-1:0] pt_r;
  logic [4:0]       phase_r, phase_nxt;
  cmd_t             mode_r, mode_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic             ackc_r, ackc_nxt;
  logic [7:0]       rx_r, rx_nxt;
  logic             ackh_r, ackh_nxt;
  logic             scl_r, scl_nxt;
  logic             drv_r, drv_nxt;
  logic             lvl_r, lvl_nxt;
  logic             done;
  logic             do_enter;
  logic [TickW-1:0] limit;
  logic [TickW:0]   tick_inc;

  assign limit    = (pt_r == '0) ? {{(TickW-1){1'b0}}, 1'b1} : pt_r;
  assign tick_inc = {1'b0, tick_r} + {{TickW{1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    slot_nxt  = slot_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    ackc_nxt  = ackc_r;
    rx_nxt    = rx_r;
    ackh_nxt  = ackh_r;
    scl_nxt   = scl_r;
    drv_nxt   = drv_r;
    lvl_nxt   = lvl_r;
    done      = 1'b0;
    do_enter  = 1'b0;

    if (phase_r == PHASE_IDLE) begin
      if (item.cmd_valid) begin
        mode_nxt  = item.mode;
        shift_nxt = (item.mode == CMD_WRITE) ? item.tx_byte : 8'd0;
        ackc_nxt  = item.send_ack;
        tick_nxt  = '0;
        phase_nxt = 5'd0;
        slot_nxt  = 2'd0;
        do_enter  = 1'b1;
      end
    end else if (tick_inc >= {1'b0, limit}) begin
      // Sample due at the end of the current phase.
      if (mode_r == CMD_WRITE && phase_r == PH_WR_ACK) begin
        ackh_nxt = item.sda_in;
      end else if (mode_r == CMD_READ && phase_r < PH_RD_ACK && !phase_r[0]) begin
        shift_nxt = {shift_r[6:0], item.sda_in};
      end
      tick_nxt = '0;
      if (phase_r == phase_last(mode_r)) begin
        if (mode_r == CMD_WRITE) begin
          drv_nxt = 1'b1;
        end else if (mode_r == CMD_READ) begin
          drv_nxt = 1'b0;
          rx_nxt  = shift_nxt;
        end
        phase_nxt = PHASE_IDLE;
        done      = 1'b1;
      end else begin
        phase_nxt = phase_r + 5'd1;
        slot_nxt  = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
        do_enter  = 1'b1;
      end
    end else begin
      tick_nxt = tick_inc[TickW-1:0];
    end

    // Pin actions on entry to a phase.
    if (do_enter) begin
      unique case (mode_nxt)
        CMD_START: begin
          if (phase_nxt == 5'd0) begin
            drv_nxt = 1'b1;
            lvl_nxt = 1'b1;
          end else if (phase_nxt == 5'd1) scl_nxt = 1'b1;
          else if (phase_nxt == 5'd2) lvl_nxt = 1'b0;
          else scl_nxt = 1'b0;
        end
        CMD_STOP: begin
          if (phase_nxt == 5'd0) begin
            drv_nxt = 1'b1;
            lvl_nxt = 1'b0;
          end else if (phase_nxt == 5'd1) scl_nxt = 1'b1;
          else lvl_nxt = 1'b1;
        end
        CMD_WRITE: begin
          if (phase_nxt < PH_WR_REL) begin
            if (slot_nxt == 2'd0) begin
              drv_nxt   = 1'b1;
              lvl_nxt   = shift_nxt[7];
              shift_nxt = {shift_nxt[6:0], 1'b0};
            end else if (slot_nxt == 2'd1) scl_nxt = 1'b1;
            else scl_nxt = 1'b0;
          end else if (phase_nxt == PH_WR_REL) drv_nxt = 1'b0;
          else if (phase_nxt == PH_WR_ACK) scl_nxt = 1'b1;
          else scl_nxt = 1'b0;
        end
        CMD_READ: begin
          if (phase_nxt < PH_RD_ACK) begin
            if (!phase_nxt[0]) begin
              if (phase_nxt == 5'd0) drv_nxt = 1'b0;
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
          end else if (phase_nxt == PH_RD_ACK) begin
            drv_nxt = 1'b1;
            lvl_nxt = !ackc_nxt;
          end else if (phase_nxt == PH_RD_HIGH) scl_nxt = 1'b1;
          else scl_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_drive = drv_nxt;
    res.sda_level = drv_nxt & lvl_nxt;
    res.busy_res  = (phase_nxt != PHASE_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_nxt;
    res.ack_level = ackh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r    <= PHASE_TICKS_RST;
      phase_r <= PHASE_IDLE;
      mode_r  <= CMD_START;
      slot_r  <= 2'd0;
      shift_r <= 8'd0;
      tick_r  <= '0;
      ackc_r  <= 1'b0;
      rx_r    <= 8'd0;
      ackh_r  <= 1'b1;
      scl_r   <= 1'b1;
      drv_r   <= 1'b1;
      lvl_r   <= 1'b1;
    end else begin
      if (cfg_we) pt_r <= cfg_data;
      if (go) begin
        phase_r <= phase_nxt;
        mode_r  <= mode_nxt;
        slot_r  <= slot_nxt;
        shift_r <= shift_nxt;
        tick_r  <= tick_nxt;
        ackc_r  <= ackc_nxt;
        rx_r    <= rx_nxt;
        ackh_r  <= ackh_nxt;
        scl_r   <= scl_nxt;
        drv_r   <= drv_nxt;
        lvl_r   <= lvl_nxt;
      end
    end
  end

endmodule

// ===== hdl/i2cbm_resq.sv =====
// Result queue: holds finished items until the consumer pops them.
module i2cbm_resq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  i2cbm_pkg::res_t  wdata,
  output logic             room,
  input  logic             pop,
  output logic             empty,
  output i2cbm_pkg::res_t  rdata
);
  import i2cbm_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       rd_en;

  assign room  = (cnt_r != 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rd_en = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      if (wr && !rd_en) cnt_r <= cnt_r + 2'd1;
      else if (rd_en && !wr) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== hdl/i2c_byte_master.sv =====
// An accepted item waits in the input queue until the result queue has room; the engine's result
// for it is then stored there and shown on the out_ ports. One item per cycle while there is room.
// A two-entry input queue and a two-entry result queue let either side stall on its own.
// Reset (synchronous, rst_n low): both queues empty, engine idle, phase_ticks = 50,
// SCL high and SDA driven high, ack level 1, received byte 0.
module i2c_byte_master (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_cmd_valid,
  input  logic [1:0]                  in_mode,
  input  logic [7:0]                  in_tx_byte,
  input  logic                        in_send_ack,
  input  logic                        in_sda_in,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_scl_level,
  output logic                        out_sda_drive,
  output logic                        out_sda_level,
  output logic                        out_busy_res,
  output logic                        out_done_res,
  output logic [7:0]                  out_rx_byte,
  output logic                        out_ack_level,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [i2cbm_pkg::TickW-1:0] cfg_phase_ticks
);
  import i2cbm_pkg::*;

  item_t item;
  res_t  res, res_q;
  logic  avail, room, go;

  // The phase-tick register is written only while no item waits in the input
  // queue, so every queued item is processed with the value in force when it
  // was sent.
  assign cfg_ready = ~avail;

  // The engine consumes one queued tick whenever the result queue can take
  // the item it produces.
  assign go = avail && room;

  i2cbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .cmd_valid (in_cmd_valid),
    .mode      (in_mode),
    .tx_byte   (in_tx_byte),
    .send_ack  (in_send_ack),
    .sda_in    (in_sda_in),
    .deq       (go),
    .avail     (avail),
    .item      (item)
  );

  i2cbm_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_phase_ticks),
    .res      (res)
  );

  i2cbm_resq u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (go),
    .wdata (res),
    .room  (room),
    .pop   (pop),
    .empty (empty),
    .rdata (res_q)
  );

  // The result fields come straight from the head of the result queue.
  assign out_scl_level = res_q.scl_level;
  assign out_sda_drive = res_q.sda_drive;
  assign out_sda_level = res_q.sda_level;
  assign out_busy_res  = res_q.busy_res;
  assign out_done_res  = res_q.done_res;
  assign out_rx_byte   = res_q.rx_byte;
  assign out_ack_level = res_q.ack_level;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the I2C byte master: random command ticks in, predicted pin states out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbm_pkg::*;

  // Roughly how many ticks the whole run offers to the block.
  localparam int ItemTarget   = 1150;
  // Each tick the block takes leads to exactly one result, so a few spare
  // cycles after the last result are enough to see anything stray.
  localparam int SettleCycles = 6;
  // Cycles the receiver holds off during the backpressure test.
  localparam int LongHold     = 120;
  // Longest legal quiet stretch is the long hold plus one sender or receiver
  // gap; the watchdog allows many times that.
  localparam int StallLimit   = 2000;
  localparam int ReportMax    = 10;

  // Where the SDA level seen on the bus comes from for the next ticks.
  typedef enum {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_src_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 push            = 1'b0;
  logic                 full;
  logic                 in_cmd_valid    = 1'b0;
  logic [1:0]           in_mode         = 2'b00;
  logic [7:0]           in_tx_byte      = 8'h00;
  logic                 in_send_ack     = 1'b0;
  logic                 in_sda_in       = 1'b0;
  logic                 empty;
  logic                 pop             = 1'b0;
  logic                 out_scl_level;
  logic                 out_sda_drive;
  logic                 out_sda_level;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [7:0]           out_rx_byte;
  logic                 out_ack_level;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [TickW-1:0]     cfg_phase_ticks = '0;

  i2c_byte_master dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd_valid    (in_cmd_valid),
    .in_mode         (in_mode),
    .in_tx_byte      (in_tx_byte),
    .in_send_ack     (in_send_ack),
    .in_sda_in       (in_sda_in),
    .empty           (empty),
    .pop             (pop),
    .out_scl_level   (out_scl_level),
    .out_sda_drive   (out_sda_drive),
    .out_sda_level   (out_sda_level),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_ack_level   (out_ack_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_phase_ticks (cfg_phase_ticks)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bus engine predictor. These variables mirror the engine after every tick
  // that the block has taken, in the same order, so the sender can also use
  // them to know whether the engine is idle before it offers a command.
  // ---------------------------------------------------------------------------
  logic [4:0]       bus_phase     = PHASE_IDLE;
  cmd_t             bus_cmd       = CMD_START;
  logic [7:0]       bus_shift     = 8'h00;
  logic [15:0]      bus_ticks     = 16'd0;
  logic             bus_ack_sel   = 1'b0;
  logic [7:0]       bus_rx        = 8'h00;
  logic             bus_ack       = 1'b1;
  logic             bus_scl       = 1'b1;
  logic             bus_drv       = 1'b1;
  logic             bus_lvl       = 1'b1;
  logic [TickW-1:0] phase_period  = PHASE_TICKS_RST;

  // Predicted pin states, one per tick taken, oldest first.
  res_t      pin_state_q[$];

  int        ticks_sent    = 0;
  int        results_seen  = 0;
  int        mismatch_cnt  = 0;
  int        stall_cycles  = 0;
  int        rx_hold_req   = 0;
  bit        tx_burst      = 1'b0;
  bit        tx_steady     = 1'b0;
  bit        rx_burst      = 1'b0;
  sda_src_t  sda_src       = SDA_RANDOM;

  // Number of bus phases that make up each command.
  function automatic int phase_count(input cmd_t m);
    case (m)
      CMD_START: return 4;
      CMD_STOP:  return 3;
      CMD_WRITE: return 27;
      default:   return 19;
    endcase
  endfunction

  // Pin actions taken on entry to bus phase p of the running command.
  function automatic void apply_phase(input int p);
    case (bus_cmd)
      CMD_START: begin
        // SDA high, SCL high, then SDA falls while SCL is high, then SCL low.
        case (p)
          0: begin
            bus_drv = 1'b1;
            bus_lvl = 1'b1;
          end
          1: bus_scl = 1'b1;
          2: bus_lvl = 1'b0;
          default: bus_scl = 1'b0;
        endcase
      end
      CMD_STOP: begin
        // SDA low, SCL high, then SDA rises while SCL is high.
        case (p)
          0: begin
            bus_drv = 1'b1;
            bus_lvl = 1'b0;
          end
          1: bus_scl = 1'b1;
          default: bus_lvl = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        if (p < PH_WR_REL) begin
          // Three phases per data bit: present the bit, clock high, clock low.
          case (p % 3)
            0: begin
              bus_drv   = 1'b1;
              bus_lvl   = bus_shift[7];
              bus_shift = {bus_shift[6:0], 1'b0};
            end
            1: bus_scl = 1'b1;
            default: bus_scl = 1'b0;
          endcase
        end else if (p == PH_WR_REL) begin
          // Let go of SDA so the target can answer in the ack slot.
          bus_drv = 1'b0;
        end else begin
          bus_scl = (p == PH_WR_ACK);
        end
      end
      default: begin
        if (p < PH_RD_ACK) begin
          // Two phases per received bit; SDA is released on the very first.
          if (p % 2 == 0) begin
            if (p == 0) bus_drv = 1'b0;
            bus_scl = 1'b1;
          end else begin
            bus_scl = 1'b0;
          end
        end else if (p == PH_RD_ACK) begin
          // Our own ack slot: low to acknowledge, high to refuse.
          bus_drv = 1'b1;
          bus_lvl = ~bus_ack_sel;
        end else begin
          bus_scl = (p == PH_RD_HIGH);
        end
      end
    endcase
  endfunction

  // Advance the predictor by one tick and return the pin state it leads to.
  task automatic bus_tick(input item_t it, output res_t r);
    int   lim;
    int   nxt;
    logic fin;
    fin = 1'b0;
    // A period of zero behaves as a period of one.
    lim = (phase_period == '0) ? 1 : int'(phase_period);
    if (bus_phase == PHASE_IDLE) begin
      // Only an idle engine takes a command, and the first phase starts at once.
      if (it.cmd_valid) begin
        bus_cmd     = it.mode;
        bus_shift   = (it.mode == CMD_WRITE) ? it.tx_byte : 8'h00;
        bus_ack_sel = it.send_ack;
        bus_ticks   = 16'd0;
        bus_phase   = 5'd0;
        apply_phase(0);
      end
    end else if (int'(bus_ticks) + 1 >= lim) begin
      // The phase ends on this tick; a sample due at its end uses this tick's SDA.
      if (bus_cmd == CMD_WRITE && bus_phase == PH_WR_ACK) begin
        bus_ack = it.sda_in;
      end else if (bus_cmd == CMD_READ && bus_phase < PH_RD_ACK && !bus_phase[0]) begin
        bus_shift = {bus_shift[6:0], it.sda_in};
      end
      bus_ticks = 16'd0;
      nxt = int'(bus_phase) + 1;
      if (nxt >= phase_count(bus_cmd)) begin
        // Command complete: a write takes SDA back, a read hands over its byte.
        if (bus_cmd == CMD_WRITE) begin
          bus_drv = 1'b1;
        end else if (bus_cmd == CMD_READ) begin
          bus_drv = 1'b0;
          bus_rx  = bus_shift;
        end
        bus_phase = PHASE_IDLE;
        fin = 1'b1;
      end else begin
        bus_phase = nxt[4:0];
        apply_phase(nxt);
      end
    end else begin
      bus_ticks = bus_ticks + 16'd1;
    end
    r.scl_level = bus_scl;
    r.sda_drive = bus_drv;
    r.sda_level = bus_drv & bus_lvl;
    r.busy_res  = (bus_phase != PHASE_IDLE);
    r.done_res  = fin;
    r.rx_byte   = bus_rx;
    r.ack_level = bus_ack;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic bus_sda();
    case (sda_src)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic item_t make_tick(input logic valid, input cmd_t m, input logic [7:0] b,
                                      input logic ack);
    item_t it;
    it.cmd_valid = valid;
    it.mode      = m;
    it.tx_byte   = b;
    it.send_ack  = ack;
    it.sda_in    = bus_sda();
    return it;
  endfunction

  // A tick with random command fields; they only matter when valid is set.
  function automatic item_t random_tick(input logic valid);
    return make_tick(valid, cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
  endfunction

  // Offer one tick after a random gap and record its predicted pin state once
  // the block takes it. The push line is left high on return, so a following
  // item with no gap goes out on the very next edge.
  task automatic send_item(input item_t it);
    int   gap;
    res_t r;
    gap = (tx_steady || tx_burst) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_cmd_valid <= it.cmd_valid;
    in_mode      <= it.mode;
    in_tx_byte   <= it.tx_byte;
    in_send_ack  <= it.send_ack;
    in_sda_in    <= it.sda_in;
    do @(posedge clk); while (full !== 1'b0);
    bus_tick(it, r);
    pin_state_q.push_back(r);
    ticks_sent++;
    // Switch now and then between gappy traffic and back-to-back stretches.
    if ($urandom_range(0, 40) == 0) tx_burst = ~tx_burst;
  endtask

  task automatic send_idle(input int n);
    repeat (n) send_item(random_tick(1'b0));
  endtask

  // Keep ticking until the engine has finished its command. With noise on,
  // about one tick in four offers a command, which a busy engine ignores.
  task automatic finish_command(input bit noisy);
    while (bus_phase != PHASE_IDLE) begin
      send_item(random_tick(noisy && $urandom_range(0, 3) == 0));
    end
  endtask

  task automatic run_command(input cmd_t m, input logic [7:0] b, input logic ack,
                             input bit noisy);
    send_item(make_tick(1'b1, m, b, ack));
    finish_command(noisy);
  endtask

  // Stop offering and wait until every predicted pin state has been seen,
  // then a few more cycles so nothing is left in flight inside the block.
  task automatic pause_until_drained();
    push <= 1'b0;
    while (pin_state_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the phase length. Always done with the pipeline empty; the engine
  // itself may still be in the middle of a command.
  task automatic set_period(input logic [TickW-1:0] v);
    pause_until_drained();
    cfg_valid       <= 1'b1;
    cfg_phase_ticks <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid    <= 1'b0;
    phase_period = v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Pins after reset, then one start condition at the reset phase length.
  task automatic test_reset_timing();
    send_idle(3);
    run_command(CMD_START, 8'h00, 1'b0, 1'b0);
    send_idle(2);
  endtask

  // Every command at a one-tick phase, with the data and ack extremes.
  task automatic test_directed_commands();
    set_period(16'd1);
    run_command(CMD_START, 8'h00, 1'b0, 1'b0);
    sda_src = SDA_LOW;                  // target acknowledges
    run_command(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
    sda_src = SDA_HIGH;                 // target refuses
    run_command(CMD_WRITE, 8'h00, 1'b0, 1'b0);
    sda_src = SDA_RANDOM;               // commands offered while busy
    run_command(CMD_WRITE, 8'hA5, 1'b1, 1'b1);
    sda_src = SDA_HIGH;                 // all-ones byte, we acknowledge
    run_command(CMD_READ, 8'h00, 1'b1, 1'b0);
    sda_src = SDA_LOW;                  // all-zeros byte, we refuse
    run_command(CMD_READ, 8'hFF, 1'b0, 1'b1);
    sda_src = SDA_RANDOM;
    run_command(CMD_READ, 8'h5A, 1'b1, 1'b0);
    run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
    send_idle(2);
  endtask

  // Largest and zero phase lengths, and lengths changed in the middle of a phase.
  task automatic test_period_extremes();
    set_period(16'hFFFF);
    send_item(make_tick(1'b1, CMD_WRITE, 8'h3C, 1'b0));
    send_idle(20);
    // The tick count is already past one, so the phase ends on the next tick.
    set_period(16'h0000);
    finish_command(1'b1);
    run_command(CMD_READ, 8'h00, 1'b1, 1'b0);
    set_period(16'd5);
    send_item(make_tick(1'b1, CMD_START, 8'h00, 1'b0));
    send_idle(3);
    // Shortened below the ticks already counted in the current phase.
    set_period(16'd2);
    finish_command(1'b0);
  endtask

  // Receiver holds off while the sender streams ticks, so the block fills up
  // and pushes back; then the sender waits for every result.
  task automatic test_backpressure();
    set_period(16'd1);
    tx_steady   = 1'b1;
    rx_hold_req = LongHold;
    run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    run_command(CMD_READ, 8'h00, 1'($urandom_range(0, 1)), 1'b0);
    tx_steady = 1'b0;
    pause_until_drained();
  endtask

  // Mostly well-formed transactions (start, a few data bytes, stop) with
  // random content, mixed with loose commands in any order.
  task automatic test_random_traffic();
    logic [TickW-1:0] periods [7];
    int               base;
    int               stop_at;
    int               n;
    periods = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd0, 16'd4, 16'd1};
    base    = ticks_sent;
    foreach (periods[i]) begin
      set_period(periods[i]);
      // Each length runs up to its share of the total, counted from the start
      // of this test, so running past one share shortens the next.
      stop_at = base + ((ItemTarget - base) * (i + 1)) / 7;
      if (stop_at < ticks_sent + 40) stop_at = ticks_sent + 40;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(0, 4) != 0) begin
          run_command(CMD_START, 8'h00, 1'b0, 1'($urandom_range(0, 1)));
          n = $urandom_range(1, 3);
          repeat (n) begin
            run_command($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
          end
          run_command(CMD_STOP, 8'h00, 1'b0, 1'($urandom_range(0, 1)));
        end else begin
          run_command(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        send_idle($urandom_range(0, 2));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing: reset once, run the tests in turn, then give the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_timing();
    test_directed_commands();
    test_period_extremes();
    test_backpressure();
    test_random_traffic();
    pause_until_drained();
    if (mismatch_cnt == 0 && pin_state_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: pop with random gaps (or a long hold when asked) and compare
  // each result with the oldest prediction. Outputs are read right after the
  // edge, so they still hold the values the edge itself saw.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportMax) begin
        $display("%0t: result %0d %s expected %0h, got %0h", $time, results_seen, name,
                 want, got);
      end
    end
  endtask

  initial begin : result_checker
    int   gap;
    res_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req > 0) begin
        pop <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (pin_state_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportMax) begin
          $display("%0t: result %0d arrived with no prediction waiting", $time, results_seen);
        end
      end else begin
        want = pin_state_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_scl_level));
        check_field("sda_drive", 8'(want.sda_drive), 8'(out_sda_drive));
        check_field("sda_level", 8'(want.sda_level), 8'(out_sda_level));
        check_field("busy_res",  8'(want.busy_res),  8'(out_busy_res));
        check_field("done_res",  8'(want.done_res),  8'(out_done_res));
        check_field("rx_byte",   want.rx_byte,       out_rx_byte);
        check_field("ack_level", 8'(want.ack_level), 8'(out_ack_level));
      end
      results_seen++;
      if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
    end
  end

  // Watchdog: any handshake on any channel counts as progress. A long run of
  // cycles without one means the block has hung.
  always @(posedge clk) begin
    if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
